// ----- src/i2cms_pkg.sv -----
// Shared types and constants of the I2C master transfer sequencer.
// Holds status codes, control codes, register indexes and word layouts.
// No dependencies.
package i2cms_pkg;

    // Input word commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    // Bus controller status codes (low three bits masked off)
    localparam logic [7:0] STATUS_MASK     = 8'hF8;
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_RESTART      = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK   = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST     = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK   = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK  = 8'h58;

    // Clears the read/write bit of the slave address
    localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

    // Start and acknowledge control codes
    localparam logic [1:0] CTL_KEEP  = 2'd0;
    localparam logic [1:0] CTL_SET   = 2'd1;
    localparam logic [1:0] CTL_CLEAR = 2'd2;

    // End status codes
    localparam logic [1:0] END_BUSY = 2'd0;
    localparam logic [1:0] END_DONE = 2'd1;
    localparam logic [1:0] END_FAIL = 2'd2;

    // Sub-address modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLAVE_ADDRESS     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUB_ADDRESS       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUB_ADDRESS_BYTES = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SUB_ADDRESS_MODE  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRANSFER_LENGTH   = 3'd4;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] sub_address;
        logic [1:0]  sub_address_bytes;
        logic [1:0]  sub_address_mode;
        logic [15:0] transfer_length;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [7:0] tx_byte;
    } t_item;

    typedef struct packed {
        logic        load_data;
        logic [7:0]  data_byte;
        logic        take_tx;
        logic        store_rx;
        logic [7:0]  stored_byte;
        logic [15:0] buffer_position;
        logic        clear_interrupt;
        logic [1:0]  start_control;
        logic        set_stop;
        logic [1:0]  ack_control;
        logic [1:0]  end_status;
    } t_result;

endpackage

// ----- src/i2cms_decide.sv -----
// Status event decoder of the I2C master transfer sequencer.
// Computes the next working state and the result word for one input word.
// Depends on i2cms_pkg.
module i2cms_decide #(
    parameter int COUNT_WIDTH = 16
) (
    input  i2cms_pkg::t_cfg         i_cfg,
    input  i2cms_pkg::t_item        i_item,
    input  logic [1:0]              i_mode_now,
    input  logic [1:0]              i_subaddr_left,
    input  logic [COUNT_WIDTH-1:0]  i_bytes_left,
    input  logic [COUNT_WIDTH-1:0]  i_buffer_index,
    input  logic [1:0]              i_end_flag,
    output logic [1:0]              o_mode_now,
    output logic [1:0]              o_subaddr_left,
    output logic [COUNT_WIDTH-1:0]  o_bytes_left,
    output logic [COUNT_WIDTH-1:0]  o_buffer_index,
    output logic [1:0]              o_end_flag,
    output i2cms_pkg::t_result      o_result
);

    logic [7:0]             w_status;
    logic [COUNT_WIDTH-1:0] w_index_inc;
    logic                   w_bytes_nz;

    assign w_status    = i_item.status_code & i2cms_pkg::STATUS_MASK;
    assign w_index_inc = i_buffer_index + COUNT_WIDTH'(1);
    assign w_bytes_nz  = (i_bytes_left != '0);

    always_comb begin
        o_mode_now     = i_mode_now;
        o_subaddr_left = i_subaddr_left;
        o_bytes_left   = i_bytes_left;
        o_buffer_index = i_buffer_index;
        o_end_flag     = i_end_flag;
        o_result       = '0;

        if (i_item.cmd == i2cms_pkg::CMD_START) begin
            // Load working copies of the transfer settings
            o_mode_now     = i_cfg.sub_address_mode;
            o_subaddr_left = i_cfg.sub_address_bytes;
            o_bytes_left   = COUNT_WIDTH'(i_cfg.transfer_length);
            o_buffer_index = '0;
            o_end_flag     = i2cms_pkg::END_BUSY;
        end else begin
            case (w_status)
                i2cms_pkg::ST_START: begin
                    o_result.load_data       = 1'b1;
                    o_result.data_byte       = (i_mode_now == i2cms_pkg::MODE_READ) ?
                        (i_cfg.slave_address & i2cms_pkg::ADDR_WRITE_MASK) :
                        i_cfg.slave_address;
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_RESTART: begin
                    o_result.load_data       = 1'b1;
                    o_result.data_byte       = i_cfg.slave_address;
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
                    if (i_mode_now == i2cms_pkg::MODE_NONE) begin
                        o_result.clear_interrupt = 1'b1;
                        o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                        if (w_bytes_nz) begin
                            o_result.load_data       = 1'b1;
                            o_result.data_byte       = i_item.tx_byte;
                            o_result.take_tx         = 1'b1;
                            o_result.buffer_position = 16'(i_buffer_index);
                            o_buffer_index           = w_index_inc;
                            o_bytes_left             = i_bytes_left - COUNT_WIDTH'(1);
                        end else begin
                            o_result.set_stop = 1'b1;
                            o_end_flag        = i2cms_pkg::END_DONE;
                        end
                    end else if (i_mode_now inside {i2cms_pkg::MODE_READ,
                                                    i2cms_pkg::MODE_WRITE}) begin
                        if (i_subaddr_left == 2'd2) begin
                            o_result.load_data       = 1'b1;
                            o_result.data_byte       = i_cfg.sub_address[15:8];
                            o_result.clear_interrupt = 1'b1;
                            o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                            o_subaddr_left           = 2'd1;
                        end else if (i_subaddr_left == 2'd1) begin
                            o_result.load_data       = 1'b1;
                            o_result.data_byte       = i_cfg.sub_address[7:0];
                            o_result.clear_interrupt = 1'b1;
                            o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                            o_subaddr_left           = 2'd0;
                            if (i_mode_now == i2cms_pkg::MODE_WRITE) begin
                                o_mode_now = i2cms_pkg::MODE_NONE;
                            end
                        end else if (i_subaddr_left == 2'd0 &&
                                     i_mode_now == i2cms_pkg::MODE_READ) begin
                            // Sub-address done: issue the repeated start
                            o_result.clear_interrupt = 1'b1;
                            o_result.start_control   = i2cms_pkg::CTL_SET;
                            o_mode_now               = i2cms_pkg::MODE_NONE;
                        end
                    end
                end
                i2cms_pkg::ST_SLA_R_ACK: begin
                    o_result.ack_control     = (i_bytes_left <= COUNT_WIDTH'(1)) ?
                        i2cms_pkg::CTL_CLEAR : i2cms_pkg::CTL_SET;
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
                i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_SLA_R_NACK: begin
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                    o_end_flag               = i2cms_pkg::END_FAIL;
                end
                i2cms_pkg::ST_DATA_R_ACK: begin
                    o_result.store_rx        = 1'b1;
                    o_result.stored_byte     = i_item.rx_byte;
                    o_result.buffer_position = 16'(i_buffer_index);
                    o_buffer_index           = w_index_inc;
                    // Count down, holding at zero
                    if (w_bytes_nz) begin
                        o_bytes_left = i_bytes_left - COUNT_WIDTH'(1);
                    end
                    o_result.ack_control     = (o_bytes_left == COUNT_WIDTH'(1)) ?
                        i2cms_pkg::CTL_CLEAR : i2cms_pkg::CTL_SET;
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_DATA_R_NACK: begin
                    o_result.store_rx        = 1'b1;
                    o_result.stored_byte     = i_item.rx_byte;
                    o_result.buffer_position = 16'(i_buffer_index);
                    o_buffer_index           = w_index_inc;
                    o_result.set_stop        = 1'b1;
                    o_result.clear_interrupt = 1'b1;
                    o_result.start_control   = i2cms_pkg::CTL_CLEAR;
                    o_end_flag               = i2cms_pkg::END_DONE;
                end
                default: begin
                end
            endcase
        end

        o_result.end_status = o_end_flag;
    end

endmodule

// ----- src/i2c_master_transfer_sequencer.sv -----
// An accepted word's result is registered in the output slot or else the skid slot.
// Throughput: one word per cycle while the skid slot is empty; the decision for each
// word is shallow logic on the working counters, and a result register plus a skid
// register let one more word in while a result waits on the output.
// Reset (synchronous, active low) clears configuration, working state and the valid
// flags of both output slots. Depends on i2cms_pkg and i2cms_decide.
module i2c_master_transfer_sequencer #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration write port
    input  logic                                   i_cfg_wr_en,
    input  logic [i2cms_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_wdata,
    // Input words
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_cmd,
    input  logic [7:0]                             i_status_code,
    input  logic [7:0]                             i_rx_byte,
    input  logic [7:0]                             i_tx_byte,
    // Result words
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_load_data,
    output logic [7:0]                             o_data_byte,
    output logic                                   o_take_tx,
    output logic                                   o_store_rx,
    output logic [7:0]                             o_stored_byte,
    output logic [15:0]                            o_buffer_position,
    output logic                                   o_clear_interrupt,
    output logic [1:0]                             o_start_control,
    output logic                                   o_set_stop,
    output logic [1:0]                             o_ack_control,
    output logic [1:0]                             o_end_status
);

    // Configuration registers
    i2cms_pkg::t_cfg r_cfg;

    // Working state of the current transfer
    logic [1:0]             r_mode_now;
    logic [1:0]             r_subaddr_left;
    logic [COUNT_WIDTH-1:0] r_bytes_left;
    logic [COUNT_WIDTH-1:0] r_buffer_index;
    logic [1:0]             r_end_flag;

    logic [1:0]             n_mode_now;
    logic [1:0]             n_subaddr_left;
    logic [COUNT_WIDTH-1:0] n_bytes_left;
    logic [COUNT_WIDTH-1:0] n_buffer_index;
    logic [1:0]             n_end_flag;

    // Output slot and skid slot
    i2cms_pkg::t_result r_out;
    i2cms_pkg::t_result r_skid;
    logic               r_out_valid;
    logic               r_skid_valid;

    i2cms_pkg::t_item   w_item;
    i2cms_pkg::t_result w_result;
    logic               w_accept;
    logic               w_out_free;

    assign w_item.cmd         = i_cmd;
    assign w_item.status_code = i_status_code;
    assign w_item.rx_byte     = i_rx_byte;
    assign w_item.tx_byte     = i_tx_byte;

    // Take a new word as long as the skid slot is empty
    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    // Output slot can take a word this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                i2cms_pkg::CFG_SLAVE_ADDRESS: begin
                    r_cfg.slave_address <= i_cfg_wdata[7:0];
                end
                i2cms_pkg::CFG_SUB_ADDRESS: begin
                    r_cfg.sub_address <= i_cfg_wdata[15:0];
                end
                i2cms_pkg::CFG_SUB_ADDRESS_BYTES: begin
                    r_cfg.sub_address_bytes <= i_cfg_wdata[1:0];
                end
                i2cms_pkg::CFG_SUB_ADDRESS_MODE: begin
                    r_cfg.sub_address_mode <= i_cfg_wdata[1:0];
                end
                i2cms_pkg::CFG_TRANSFER_LENGTH: begin
                    r_cfg.transfer_length <= i_cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Status decision for the word at the input
    i2cms_decide #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decide (
        .i_cfg          (r_cfg),
        .i_item         (w_item),
        .i_mode_now     (r_mode_now),
        .i_subaddr_left (r_subaddr_left),
        .i_bytes_left   (r_bytes_left),
        .i_buffer_index (r_buffer_index),
        .i_end_flag     (r_end_flag),
        .o_mode_now     (n_mode_now),
        .o_subaddr_left (n_subaddr_left),
        .o_bytes_left   (n_bytes_left),
        .o_buffer_index (n_buffer_index),
        .o_end_flag     (n_end_flag),
        .o_result       (w_result)
    );

    // Advance working state on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_now     <= '0;
            r_subaddr_left <= '0;
            r_bytes_left   <= '0;
            r_buffer_index <= '0;
            r_end_flag     <= '0;
        end else if (w_accept) begin
            r_mode_now     <= n_mode_now;
            r_subaddr_left <= n_subaddr_left;
            r_bytes_left   <= n_bytes_left;
            r_buffer_index <= n_buffer_index;
            r_end_flag     <= n_end_flag;
        end
    end

    // Slot valid flags: the skid slot drains into the output slot first,
    // so words leave in the order they came in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Slot payloads
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_load_data       = r_out.load_data;
    assign o_data_byte       = r_out.data_byte;
    assign o_take_tx         = r_out.take_tx;
    assign o_store_rx        = r_out.store_rx;
    assign o_stored_byte     = r_out.stored_byte;
    assign o_buffer_position = r_out.buffer_position;
    assign o_clear_interrupt = r_out.clear_interrupt;
    assign o_start_control   = r_out.start_control;
    assign o_set_stop        = r_out.set_stop;
    assign o_ack_control     = r_out.ack_control;
    assign o_end_status      = r_out.end_status;

`ifndef SYNTHESIS
    // Skid slot only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a word while output slot is empty");

    // A start word clears the buffer index and end flag
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == i2cms_pkg::CMD_START) |=>
        (r_buffer_index == '0 && r_end_flag == i2cms_pkg::END_BUSY))
        else $error("start word did not clear working state");

    // End flag never takes the unused code
    a_end_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end_flag == i2cms_pkg::END_BUSY || r_end_flag == i2cms_pkg::END_DONE ||
        r_end_flag == i2cms_pkg::END_FAIL)
        else $error("end flag holds an unused code");

    // One word never both consumes and stores a buffer element
    a_take_store_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.take_tx && r_out.store_rx))
        else $error("result both takes and stores a buffer element");

    // Using a buffer element advances the buffer index by exactly one
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd == i2cms_pkg::CMD_EVENT &&
         (w_result.take_tx || w_result.store_rx)) |=>
        (r_buffer_index == $past(r_buffer_index) + COUNT_WIDTH'(1)))
        else $error("buffer index did not advance by one");
`endif

endmodule

// ----- bench/i2cms_checker.sv -----
// Scoreboard for the I2C master transfer sequencer: watches the config port and both
// word channels, predicts each result word and compares it field by field.
// Depends on i2cms_pkg.
module i2cms_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [i2cms_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [i2cms_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_cmd,
    input  logic [7:0]                            i_status_code,
    input  logic [7:0]                            i_rx_byte,
    input  logic [7:0]                            i_tx_byte,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic                                  i_load_data,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_take_tx,
    input  logic                                  i_store_rx,
    input  logic [7:0]                            i_stored_byte,
    input  logic [15:0]                           i_buffer_position,
    input  logic                                  i_clear_interrupt,
    input  logic [1:0]                            i_start_control,
    input  logic                                  i_set_stop,
    input  logic [1:0]                            i_ack_control,
    input  logic [1:0]                            i_end_status,
    output int unsigned                           o_fail_count,
    output int unsigned                           o_pending
);

    i2cms_pkg::t_cfg    settings;
    logic [1:0]         xfer_mode;
    logic [1:0]         addr_bytes_due;
    logic [15:0]        count_due;
    logic [15:0]        buf_ptr;
    logic [1:0]         xfer_end;
    i2cms_pkg::t_result pending_actions[$];
    int unsigned        results_seen;

    task automatic flag_mismatch(input string what, input int unsigned seen,
                                 input int unsigned wanted);
        if (o_fail_count < 200) begin
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, seen, wanted, results_seen);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    // Work out the control decision for one word and advance the transfer state.
    task automatic decide_bus_action(input i2cms_pkg::t_item w,
                                     output i2cms_pkg::t_result r);
        logic [7:0] code;
        r = '0;
        if (w.cmd == i2cms_pkg::CMD_START) begin
            xfer_mode      = settings.sub_address_mode;
            addr_bytes_due = settings.sub_address_bytes;
            count_due      = settings.transfer_length;
            buf_ptr        = '0;
            xfer_end       = i2cms_pkg::END_BUSY;
        end else begin
            code = w.status_code & i2cms_pkg::STATUS_MASK;
            case (code)
                i2cms_pkg::ST_START: begin
                    r.load_data       = 1'b1;
                    r.data_byte       = (xfer_mode == i2cms_pkg::MODE_READ) ?
                                        (settings.slave_address &
                                         i2cms_pkg::ADDR_WRITE_MASK) :
                                        settings.slave_address;
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_RESTART: begin
                    r.load_data       = 1'b1;
                    r.data_byte       = settings.slave_address;
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_SLA_W_ACK, i2cms_pkg::ST_DATA_W_ACK: begin
                    if (xfer_mode == i2cms_pkg::MODE_NONE) begin
                        r.clear_interrupt = 1'b1;
                        r.start_control   = i2cms_pkg::CTL_CLEAR;
                        if (count_due != 0) begin
                            r.load_data       = 1'b1;
                            r.data_byte       = w.tx_byte;
                            r.take_tx         = 1'b1;
                            r.buffer_position = buf_ptr;
                            buf_ptr           = buf_ptr + 1'b1;
                            count_due         = count_due - 1'b1;
                        end else begin
                            r.set_stop = 1'b1;
                            xfer_end   = i2cms_pkg::END_DONE;
                        end
                    end else if (xfer_mode inside {i2cms_pkg::MODE_READ,
                                                   i2cms_pkg::MODE_WRITE}) begin
                        if (addr_bytes_due == 2'd2) begin
                            r.load_data       = 1'b1;
                            r.data_byte       = settings.sub_address[15:8];
                            r.clear_interrupt = 1'b1;
                            r.start_control   = i2cms_pkg::CTL_CLEAR;
                            addr_bytes_due    = 2'd1;
                        end else if (addr_bytes_due == 2'd1) begin
                            r.load_data       = 1'b1;
                            r.data_byte       = settings.sub_address[7:0];
                            r.clear_interrupt = 1'b1;
                            r.start_control   = i2cms_pkg::CTL_CLEAR;
                            addr_bytes_due    = 2'd0;
                            if (xfer_mode == i2cms_pkg::MODE_WRITE)
                                xfer_mode = i2cms_pkg::MODE_NONE;
                        end else if (addr_bytes_due == 2'd0 &&
                                     xfer_mode == i2cms_pkg::MODE_READ) begin
                            // sub-address done: ask for a repeated start
                            r.clear_interrupt = 1'b1;
                            r.start_control   = i2cms_pkg::CTL_SET;
                            xfer_mode         = i2cms_pkg::MODE_NONE;
                        end
                    end
                end
                i2cms_pkg::ST_SLA_R_ACK: begin
                    r.ack_control     = (count_due <= 1) ? i2cms_pkg::CTL_CLEAR :
                                                           i2cms_pkg::CTL_SET;
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
                i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_SLA_R_NACK: begin
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                    xfer_end          = i2cms_pkg::END_FAIL;
                end
                i2cms_pkg::ST_DATA_R_ACK: begin
                    r.store_rx        = 1'b1;
                    r.stored_byte     = w.rx_byte;
                    r.buffer_position = buf_ptr;
                    buf_ptr           = buf_ptr + 1'b1;
                    if (count_due != 0) count_due = count_due - 1'b1;
                    r.ack_control     = (count_due == 1) ? i2cms_pkg::CTL_CLEAR :
                                                           i2cms_pkg::CTL_SET;
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                end
                i2cms_pkg::ST_DATA_R_NACK: begin
                    r.store_rx        = 1'b1;
                    r.stored_byte     = w.rx_byte;
                    r.buffer_position = buf_ptr;
                    buf_ptr           = buf_ptr + 1'b1;
                    r.set_stop        = 1'b1;
                    r.clear_interrupt = 1'b1;
                    r.start_control   = i2cms_pkg::CTL_CLEAR;
                    xfer_end          = i2cms_pkg::END_DONE;
                end
                default: ;
            endcase
        end
        r.end_status = xfer_end;
    endtask

    always @(posedge i_clk) begin : watch
        i2cms_pkg::t_item   w;
        i2cms_pkg::t_result r;
        i2cms_pkg::t_result got;
        i2cms_pkg::t_result want;
        if (!i_rst_n) begin
            settings       = '0;
            xfer_mode      = i2cms_pkg::MODE_NONE;
            addr_bytes_due = '0;
            count_due      = '0;
            buf_ptr        = '0;
            xfer_end       = i2cms_pkg::END_BUSY;
            pending_actions.delete();
            o_pending     <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    i2cms_pkg::CFG_SLAVE_ADDRESS:
                        settings.slave_address     = i_cfg_wdata[7:0];
                    i2cms_pkg::CFG_SUB_ADDRESS:
                        settings.sub_address       = i_cfg_wdata;
                    i2cms_pkg::CFG_SUB_ADDRESS_BYTES:
                        settings.sub_address_bytes = i_cfg_wdata[1:0];
                    i2cms_pkg::CFG_SUB_ADDRESS_MODE:
                        settings.sub_address_mode  = i_cfg_wdata[1:0];
                    i2cms_pkg::CFG_TRANSFER_LENGTH:
                        settings.transfer_length   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                w.cmd         = i_cmd;
                w.status_code = i_status_code;
                w.rx_byte     = i_rx_byte;
                w.tx_byte     = i_tx_byte;
                decide_bus_action(w, r);
                pending_actions.push_back(r);
            end
            if (i_out_valid && i_out_ready) begin
                got.load_data       = i_load_data;
                got.data_byte       = i_data_byte;
                got.take_tx         = i_take_tx;
                got.store_rx        = i_store_rx;
                got.stored_byte     = i_stored_byte;
                got.buffer_position = i_buffer_position;
                got.clear_interrupt = i_clear_interrupt;
                got.start_control   = i_start_control;
                got.set_stop        = i_set_stop;
                got.ack_control     = i_ack_control;
                got.end_status      = i_end_status;
                if (pending_actions.size() == 0) begin
                    flag_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = pending_actions.pop_front();
                    if (got.load_data != want.load_data)
                        flag_mismatch("load_data", got.load_data, want.load_data);
                    if (got.data_byte != want.data_byte)
                        flag_mismatch("data_byte", got.data_byte, want.data_byte);
                    if (got.take_tx != want.take_tx)
                        flag_mismatch("take_tx", got.take_tx, want.take_tx);
                    if (got.store_rx != want.store_rx)
                        flag_mismatch("store_rx", got.store_rx, want.store_rx);
                    if (got.stored_byte != want.stored_byte)
                        flag_mismatch("stored_byte", got.stored_byte, want.stored_byte);
                    if (got.buffer_position != want.buffer_position)
                        flag_mismatch("buffer_position", got.buffer_position,
                                      want.buffer_position);
                    if (got.clear_interrupt != want.clear_interrupt)
                        flag_mismatch("clear_interrupt", got.clear_interrupt,
                                      want.clear_interrupt);
                    if (got.start_control != want.start_control)
                        flag_mismatch("start_control", got.start_control, want.start_control);
                    if (got.set_stop != want.set_stop)
                        flag_mismatch("set_stop", got.set_stop, want.set_stop);
                    if (got.ack_control != want.ack_control)
                        flag_mismatch("ack_control", got.ack_control, want.ack_control);
                    if (got.end_status != want.end_status)
                        flag_mismatch("end_status", got.end_status, want.end_status);
                end
                results_seen = results_seen + 1;
            end
            o_pending <= pending_actions.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the sequencer bench: clock, reset, config writes, status word stimulus
// and random back-pressure; the verdict comes from the checker's failure count.
// Depends on i2cms_pkg, i2cms_checker and i2c_master_transfer_sequencer.
module tb;

    // Mode value three has no meaning of its own; the block must treat it as inert.
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam int unsigned ITEM_TARGET = 1150;
    localparam int unsigned CHOKE_AT    = 500;
    localparam int unsigned CHOKE_SPAN  = 150;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_cfg_wr_en;
    logic [i2cms_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [i2cms_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_wdata;
    logic                                  i_in_valid;
    logic                                  o_in_ready;
    logic                                  i_cmd;
    logic [7:0]                            i_status_code;
    logic [7:0]                            i_rx_byte;
    logic [7:0]                            i_tx_byte;
    logic                                  o_out_valid;
    logic                                  i_out_ready;
    logic                                  o_load_data;
    logic [7:0]                            o_data_byte;
    logic                                  o_take_tx;
    logic                                  o_store_rx;
    logic [7:0]                            o_stored_byte;
    logic [15:0]                           o_buffer_position;
    logic                                  o_clear_interrupt;
    logic [1:0]                            o_start_control;
    logic                                  o_set_stop;
    logic [1:0]                            o_ack_control;
    logic [1:0]                            o_end_status;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycles;
    int unsigned sent;
    int unsigned burst_left;
    bit          choke_req;
    bit          choke_done;

    logic [7:0] fail_codes[4] = '{i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_DATA_W_NACK,
                                  i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_SLA_R_NACK};

    i2c_master_transfer_sequencer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_status_code     (i_status_code),
        .i_rx_byte         (i_rx_byte),
        .i_tx_byte         (i_tx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_load_data       (o_load_data),
        .o_data_byte       (o_data_byte),
        .o_take_tx         (o_take_tx),
        .o_store_rx        (o_store_rx),
        .o_stored_byte     (o_stored_byte),
        .o_buffer_position (o_buffer_position),
        .o_clear_interrupt (o_clear_interrupt),
        .o_start_control   (o_start_control),
        .o_set_stop        (o_set_stop),
        .o_ack_control     (o_ack_control),
        .o_end_status      (o_end_status)
    );

    i2cms_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_status_code     (i_status_code),
        .i_rx_byte         (i_rx_byte),
        .i_tx_byte         (i_tx_byte),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_load_data       (o_load_data),
        .i_data_byte       (o_data_byte),
        .i_take_tx         (o_take_tx),
        .i_store_rx        (o_store_rx),
        .i_stored_byte     (o_stored_byte),
        .i_buffer_position (o_buffer_position),
        .i_clear_interrupt (o_clear_interrupt),
        .i_start_control   (o_start_control),
        .i_set_stop        (o_set_stop),
        .i_ack_control     (o_ack_control),
        .i_end_status      (o_end_status),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: mix long ready stretches, random toggling and stalls of both
    // lengths; once asked, hold ready low long enough to fill the block.
    initial begin : receiver
        int unsigned pick;
        int unsigned span;
        int unsigned k;
        bit          lvl;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (choke_req && !choke_done) begin
                for (k = 0; k < CHOKE_SPAN; k++) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
                choke_done = 1'b1;
            end else begin
                pick = $urandom_range(99);
                if (pick < 40)      span = $urandom_range(1, 30);
                else if (pick < 85) span = $urandom_range(1, 20);
                else if (pick < 97) span = $urandom_range(1, 4);
                else                span = $urandom_range(20, 60);
                for (k = 0; k < span; k++) begin
                    if (pick < 40)      lvl = 1'b1;
                    else if (pick < 85) lvl = 1'($urandom_range(1));
                    else                lvl = 1'b0;
                    i_out_ready <= lvl;
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic i2cms_pkg::t_item start_word();
        i2cms_pkg::t_item w;
        w.cmd         = i2cms_pkg::CMD_START;
        w.status_code = 8'($urandom_range(255));
        w.rx_byte     = 8'($urandom_range(255));
        w.tx_byte     = 8'($urandom_range(255));
        return w;
    endfunction

    // Status event with random don't-care low bits and random data bytes.
    function automatic i2cms_pkg::t_item status_word(input logic [7:0] code);
        i2cms_pkg::t_item w;
        w.cmd         = i2cms_pkg::CMD_EVENT;
        w.status_code = (code & i2cms_pkg::STATUS_MASK) | 8'($urandom_range(7));
        w.rx_byte     = 8'($urandom_range(255));
        w.tx_byte     = 8'($urandom_range(255));
        return w;
    endfunction

    // Offer one word, optionally after an idle gap, and hold it until taken.
    task automatic offer_word(input i2cms_pkg::t_item w);
        int unsigned gap;
        int unsigned pick;
        gap = 0;
        if (choke_req && !choke_done) begin
            gap = 0;
        end else if (burst_left != 0) begin
            burst_left = burst_left - 1;
        end else begin
            pick = $urandom_range(99);
            if (pick < 5) burst_left = $urandom_range(20, 60);
            if (pick < 55)      gap = 0;
            else if (pick < 93) gap = $urandom_range(1, 3);
            else                gap = $urandom_range(8, 40);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= w.cmd;
        i_status_code <= w.status_code;
        i_rx_byte     <= w.rx_byte;
        i_tx_byte     <= w.tx_byte;
        do @(posedge i_clk); while (!o_in_ready);
        sent = sent + 1;
        if (sent == CHOKE_AT) choke_req = 1'b1;
    endtask

    // Drop valid and wait until every result has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all five registers back to back on an idle block.
    task automatic reconfigure(input i2cms_pkg::t_cfg c);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= i2cms_pkg::CFG_SLAVE_ADDRESS;
        i_cfg_wdata <= i2cms_pkg::CFG_DATA_WIDTH'(c.slave_address);
        @(posedge i_clk);
        i_cfg_index <= i2cms_pkg::CFG_SUB_ADDRESS;
        i_cfg_wdata <= c.sub_address;
        @(posedge i_clk);
        i_cfg_index <= i2cms_pkg::CFG_SUB_ADDRESS_BYTES;
        i_cfg_wdata <= i2cms_pkg::CFG_DATA_WIDTH'(c.sub_address_bytes);
        @(posedge i_clk);
        i_cfg_index <= i2cms_pkg::CFG_SUB_ADDRESS_MODE;
        i_cfg_wdata <= i2cms_pkg::CFG_DATA_WIDTH'(c.sub_address_mode);
        @(posedge i_clk);
        i_cfg_index <= i2cms_pkg::CFG_TRANSFER_LENGTH;
        i_cfg_wdata <= c.transfer_length;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // First two phases take the extremes, the rest are random with mostly
    // short transfers and an occasional unused mode or sub-address count.
    function automatic i2cms_pkg::t_cfg pick_settings(input int unsigned phase);
        i2cms_pkg::t_cfg c;
        int unsigned pick;
        if (phase == 0) begin
            c = '{slave_address: 8'hFF, sub_address: 16'hFFFF, sub_address_bytes: 2'd2,
                  sub_address_mode: i2cms_pkg::MODE_READ, transfer_length: 16'hFFFF};
        end else if (phase == 1) begin
            c = '0;
        end else begin
            c.slave_address = 8'($urandom_range(255));
            pick = $urandom_range(9);
            c.sub_address = (pick == 0) ? 16'h0000 :
                            (pick == 1) ? 16'hFFFF : 16'($urandom_range(65535));
            c.sub_address_bytes = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            pick = $urandom_range(99);
            if (pick < 30)      c.sub_address_mode = i2cms_pkg::MODE_NONE;
            else if (pick < 62) c.sub_address_mode = i2cms_pkg::MODE_READ;
            else if (pick < 93) c.sub_address_mode = i2cms_pkg::MODE_WRITE;
            else                c.sub_address_mode = MODE_SPARE;
            pick = $urandom_range(99);
            if (pick < 70)      c.transfer_length = 16'($urandom_range(6));
            else if (pick < 90) c.transfer_length = 16'($urandom_range(7, 20));
            else if (pick < 93) c.transfer_length = 16'd1;
            else if (pick < 96) c.transfer_length = 16'hFFFF;
            else                c.transfer_length = 16'($urandom_range(65535));
        end
        return c;
    endfunction

    // Play one plausible bus transfer for the current settings, sometimes cut
    // short by a failure status, sometimes sprinkled with stray status words.
    task automatic run_transfer(input i2cms_pkg::t_cfg c);
        logic [7:0]  plan[$];
        int unsigned n;
        int unsigned k;
        int unsigned cut;
        bit          reading;
        reading = 1'($urandom_range(1));
        n = (c.transfer_length > 12) ? $urandom_range(12) : c.transfer_length;
        plan.push_back(i2cms_pkg::ST_START);
        if (c.sub_address_mode == i2cms_pkg::MODE_NONE) begin
            if (reading) begin
                plan.push_back(i2cms_pkg::ST_SLA_R_ACK);
                for (k = 1; k < n; k++) plan.push_back(i2cms_pkg::ST_DATA_R_ACK);
                plan.push_back(i2cms_pkg::ST_DATA_R_NACK);
            end else begin
                plan.push_back(i2cms_pkg::ST_SLA_W_ACK);
                for (k = 0; k < n; k++) plan.push_back(i2cms_pkg::ST_DATA_W_ACK);
            end
        end else begin
            // address phase, then the remaining sub-address bytes
            plan.push_back(i2cms_pkg::ST_SLA_W_ACK);
            for (k = 1; k < c.sub_address_bytes; k++)
                plan.push_back(i2cms_pkg::ST_DATA_W_ACK);
            if (c.sub_address_mode == i2cms_pkg::MODE_READ) begin
                plan.push_back(i2cms_pkg::ST_DATA_W_ACK);
                plan.push_back(i2cms_pkg::ST_RESTART);
                plan.push_back(i2cms_pkg::ST_SLA_R_ACK);
                for (k = 1; k < n; k++) plan.push_back(i2cms_pkg::ST_DATA_R_ACK);
                plan.push_back(i2cms_pkg::ST_DATA_R_NACK);
            end else begin
                for (k = 0; k <= n; k++) plan.push_back(i2cms_pkg::ST_DATA_W_ACK);
            end
        end
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(plan.size() - 1);
            while (plan.size() > cut + 1) void'(plan.pop_back());
            plan.push_back(fail_codes[$urandom_range(3)]);
        end
        offer_word(start_word());
        foreach (plan[i]) begin
            if ($urandom_range(99) < 4) offer_word(status_word(8'($urandom_range(255))));
            offer_word(status_word(plan[i]));
        end
    endtask

    // Pure noise: random commands and status codes.
    task automatic run_noise();
        i2cms_pkg::t_item w;
        repeat ($urandom_range(3, 10)) begin
            w = status_word(8'($urandom_range(255)));
            w.cmd = 1'($urandom_range(1));
            offer_word(w);
        end
    endtask

    initial begin : stimulus
        i2cms_pkg::t_cfg c;
        int unsigned     phase;
        int unsigned     k;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_cmd         = i2cms_pkg::CMD_START;
        i_status_code = '0;
        i_rx_byte     = '0;
        i_tx_byte     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Read after a two-byte sub-address, with every status code at least once,
        // a receive past the end of the count, two unknown codes and all failures.
        reconfigure('{slave_address: 8'hFF, sub_address: 16'hC35A, sub_address_bytes: 2'd2,
                      sub_address_mode: i2cms_pkg::MODE_READ, transfer_length: 16'd2});
        offer_word('{cmd: i2cms_pkg::CMD_START, status_code: 8'hFF, rx_byte: 8'hFF,
                     tx_byte: 8'hFF});
        offer_word(status_word(i2cms_pkg::ST_START));
        offer_word(status_word(i2cms_pkg::ST_SLA_W_ACK));
        offer_word(status_word(i2cms_pkg::ST_DATA_W_ACK));
        offer_word(status_word(i2cms_pkg::ST_DATA_W_ACK));
        offer_word(status_word(i2cms_pkg::ST_RESTART));
        offer_word(status_word(i2cms_pkg::ST_SLA_R_ACK));
        offer_word('{cmd: i2cms_pkg::CMD_EVENT, status_code: i2cms_pkg::ST_DATA_R_ACK,
                     rx_byte: 8'h00, tx_byte: 8'h00});
        offer_word(status_word(i2cms_pkg::ST_DATA_R_ACK));
        offer_word(status_word(i2cms_pkg::ST_DATA_R_ACK));
        offer_word('{cmd: i2cms_pkg::CMD_EVENT, status_code: 8'h5F, rx_byte: 8'hFF,
                     tx_byte: 8'hFF});
        offer_word('{cmd: i2cms_pkg::CMD_EVENT, status_code: 8'h00, rx_byte: 8'h00,
                     tx_byte: 8'h00});
        offer_word(status_word(8'hF8));
        for (k = 0; k < 4; k++) offer_word(status_word(fail_codes[k]));

        // Unused mode value and a sub-address count of three: a write acknowledge does nothing.
        reconfigure('{slave_address: 8'h00, sub_address: 16'h0000, sub_address_bytes: 2'd3,
                      sub_address_mode: MODE_SPARE, transfer_length: 16'd0});
        offer_word(start_word());
        offer_word(status_word(i2cms_pkg::ST_START));
        offer_word(status_word(i2cms_pkg::ST_DATA_W_ACK));
        offer_word(status_word(i2cms_pkg::ST_SLA_R_ACK));

        reconfigure('{slave_address: 8'h5A, sub_address: 16'h1234, sub_address_bytes: 2'd3,
                      sub_address_mode: i2cms_pkg::MODE_WRITE, transfer_length: 16'd1});
        offer_word(start_word());
        offer_word(status_word(i2cms_pkg::ST_DATA_W_ACK));

        // Write mode without sub-address bytes: an acknowledge brings no action and the mode stays write.
        reconfigure('{slave_address: 8'h5A, sub_address: 16'h1234, sub_address_bytes: 2'd0,
                      sub_address_mode: i2cms_pkg::MODE_WRITE, transfer_length: 16'd1});
        offer_word(start_word());
        offer_word(status_word(i2cms_pkg::ST_SLA_W_ACK));

        // Random phases: new settings, then a handful of transfers each.
        phase = 0;
        while (sent < ITEM_TARGET) begin
            c = pick_settings(phase);
            reconfigure(c);
            for (k = $urandom_range(3, 8); k != 0 && sent < ITEM_TARGET; k--) begin
                if ($urandom_range(99) < 8) run_noise();
                else run_transfer(c);
            end
            phase = phase + 1;
        end

        settle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
